@@ rtl/iat_pkg.sv @@
// iat_pkg: shared types and constants for the integral-image adaptive threshold core
// no dependencies; every rtl file but iat_ram refers to it by scoped names

package iat_pkg;

  // image geometry
  localparam int unsigned MAX_WIDTH   = 512;
  localparam int unsigned MAX_HEIGHT  = 512;
  localparam int unsigned COL_W       = 9;
  localparam int unsigned ROW_W       = 9;
  localparam int unsigned ADDR_W      = COL_W + ROW_W;
  localparam int unsigned MEM_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned DIM_W       = 10;
  localparam int unsigned POS_W       = 19;
  localparam int unsigned EMIT_W      = 18;
  localparam int unsigned WIN_SHIFT   = 4;

  // data widths
  localparam int unsigned GRAY_W      = 8;
  localparam int unsigned INTEG_W     = 26;
  localparam int unsigned RSUM_W      = 17;
  localparam int unsigned KEEP_W      = 9;
  localparam int unsigned CNT_W       = 19;
  localparam int unsigned ACC_W       = INTEG_W + 1;
  localparam int unsigned PROD_W      = INTEG_W + KEEP_W;
  localparam int unsigned DIV_STEPS   = EMIT_W;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_Q8      = 2'd2;

  // reset values of the registers
  localparam logic [DIM_W-1:0]  RST_WIDTH  = 10'd512;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 10'd512;
  localparam logic [KEEP_W-1:0] RST_KEEP   = 9'd166;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // one queued item
  typedef struct packed {
    logic              cmd;
    logic [GRAY_W-1:0] gray;
  } item_t;

  // effective configuration seen by the back end
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [POS_W-1:0]  n;
    logic [DIM_W-1:0]  s;
    logic [KEEP_W-1:0] keep;
    logic              width_wr;
  } cfg_t;

endpackage

@@ rtl/iat_ram.sv @@
// iat_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module iat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/iat_front.sv @@
// iat_front: input side, takes item transfers into a two-entry queue
// depends on iat_pkg

module iat_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           command_i,
  input  logic [7:0]     gray_i,
  output iat_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           pop_i
);

  iat_pkg::item_t entry_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (!push && pop_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q].cmd  <= command_i;
      entry_q[wr_ptr_q].gray <= gray_i;
    end
  end

endmodule

@@ rtl/iat_engine.sv @@
// iat_engine: back end, builds the summed-area table and evaluates fetches
// depends on iat_pkg and iat_ram

module iat_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iat_pkg::cfg_t  cfg_i,
  input  iat_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           white_o,
  output logic [8:0]     col_o,
  output logic [8:0]     row_o,
  output logic           last_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOAD_WR = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_WIN     = 3'd3;
  localparam logic [2:0] ST_RD      = 3'd4;
  localparam logic [2:0] ST_ACC     = 3'd5;
  localparam logic [2:0] ST_MUL     = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  localparam int unsigned DCNT_W = $clog2(iat_pkg::DIV_STEPS);

  logic [2:0] state_q, state_d;

  // control state
  logic [iat_pkg::POS_W-1:0]  lp_q;
  logic [iat_pkg::COL_W-1:0]  lc_q;
  logic [iat_pkg::ROW_W-1:0]  lr_q;
  logic [iat_pkg::RSUM_W-1:0] rsum_q;
  logic                       loaded_q;
  logic [iat_pkg::EMIT_W-1:0] ep_q;
  logic [iat_pkg::COL_W-1:0]  ec_q;
  logic [iat_pkg::ROW_W-1:0]  er_q;
  logic                       stale_q;
  logic                       out_valid_q;

  // datapath registers
  logic [iat_pkg::GRAY_W-1:0] ld_gray_q;
  logic [iat_pkg::EMIT_W-1:0] dq_q;
  logic [iat_pkg::DIM_W-1:0]  drem_q;
  logic [DCNT_W-1:0]          dcnt_q;
  logic [iat_pkg::COL_W-1:0]  x1_q, x2_q;
  logic [iat_pkg::ROW_W-1:0]  y1_q, y2_q;
  logic [iat_pkg::DIM_W-1:0]  len_x_q, len_y_q;
  logic [iat_pkg::CNT_W-1:0]  cnt_q;
  logic [1:0]                 idx_q;
  logic                       pend_q, pv_q, psub_q;
  logic [iat_pkg::ACC_W-1:0]  acc_q;
  logic [iat_pkg::PROD_W-1:0] prod_a_q, prod_b_q;
  logic                       white_q, last_q;
  logic [iat_pkg::COL_W-1:0]  col_q;
  logic [iat_pkg::ROW_W-1:0]  row_q;

  // ram ports
  logic                        ir_re, ir_we;
  logic [iat_pkg::ADDR_W-1:0]  ir_raddr, wr_addr;
  logic [iat_pkg::INTEG_W-1:0] ir_rdata, integ_new;
  logic                        gr_re;
  logic [iat_pkg::GRAY_W-1:0]  gr_rdata;

  // item decode
  logic                       take, is_load, restart, fetch_ok, out_free;
  logic [iat_pkg::COL_W-1:0]  ld_c;
  logic [iat_pkg::ROW_W-1:0]  ld_r;
  logic [iat_pkg::RSUM_W-1:0] rsum_new;
  logic [iat_pkg::DIM_W-1:0]  wm1, hm1;

  // divider step
  logic [iat_pkg::DIM_W:0]    rem_sh;
  logic                       div_ge;
  logic [iat_pkg::DIM_W-1:0]  drem_d;
  logic [iat_pkg::EMIT_W-1:0] dq_d;

  // window bounds
  logic [iat_pkg::DIM_W-1:0] ec10, er10;
  logic [iat_pkg::DIM_W:0]   xs, ys;
  logic [iat_pkg::COL_W-1:0] x1_c, x2_c;
  logic [iat_pkg::ROW_W-1:0] y1_c, y2_c;

  // corner reads
  logic                       rv, rsub;
  logic [iat_pkg::ACC_W-1:0]  term, acc_next;
  logic [iat_pkg::POS_W-1:0]  ep_inc;

  assign take     = (state_q == ST_IDLE) && item_valid_i;
  assign pop_o    = take;
  assign is_load  = (item_i.cmd == iat_pkg::CMD_LOAD);
  assign restart  = loaded_q || (lp_q >= cfg_i.n);
  assign ld_c     = restart ? '0 : lc_q;
  assign ld_r     = restart ? '0 : lr_q;
  assign fetch_ok = loaded_q && (lp_q == cfg_i.n) && ({1'b0, ep_q} < cfg_i.n);
  assign out_free = !out_valid_q || !out_stall_i;
  assign wm1      = cfg_i.w - 10'd1;
  assign hm1      = cfg_i.h - 10'd1;
  assign ep_inc   = {1'b0, ep_q} + 19'd1;

  // load datapath: row running sum plus the entry above
  assign rsum_new  = ((lc_q == '0) ? '0 : rsum_q) + {9'd0, ld_gray_q};
  assign integ_new = ((lr_q != '0) ? ir_rdata : '0) + {9'd0, rsum_new};
  assign ir_we     = (state_q == ST_LOAD_WR);
  assign wr_addr   = {lr_q, lc_q};

  // restoring divider rebuilds the emit column and row after a width change
  assign rem_sh = {drem_q, dq_q[iat_pkg::EMIT_W-1]};
  assign div_ge = (rem_sh >= {1'b0, cfg_i.w});
  assign drem_d = div_ge ? iat_pkg::DIM_W'(rem_sh - {1'b0, cfg_i.w})
                         : rem_sh[iat_pkg::DIM_W-1:0];
  assign dq_d   = {dq_q[iat_pkg::EMIT_W-2:0], div_ge};

  // clamped window around the emit pixel
  assign ec10 = {1'b0, ec_q};
  assign er10 = {1'b0, er_q};
  assign xs   = {1'b0, ec10} + {1'b0, cfg_i.s};
  assign ys   = {1'b0, er10} + {1'b0, cfg_i.s};
  assign x1_c = (ec10 >= cfg_i.s) ? iat_pkg::COL_W'(ec10 - cfg_i.s) : '0;
  assign y1_c = (er10 >= cfg_i.s) ? iat_pkg::ROW_W'(er10 - cfg_i.s) : '0;
  assign x2_c = (xs > {1'b0, wm1}) ? wm1[iat_pkg::COL_W-1:0] : xs[iat_pkg::COL_W-1:0];
  assign y2_c = (ys > {1'b0, hm1}) ? hm1[iat_pkg::ROW_W-1:0] : ys[iat_pkg::ROW_W-1:0];

  // integral read address: above-entry for loads, four corners for fetches
  always_comb begin
    rv       = 1'b0;
    rsub     = 1'b0;
    ir_re    = 1'b0;
    ir_raddr = '0;
    if (take && is_load) begin
      ir_re    = (ld_r != '0);
      ir_raddr = {ld_r - 9'd1, ld_c};
    end else if (state_q == ST_RD) begin
      unique case (idx_q)
        2'd0: begin
          rv       = 1'b1;
          ir_raddr = {y2_q, x2_q};
        end
        2'd1: begin
          rv       = (x1_q != '0) && (y1_q != '0);
          ir_raddr = {y1_q - 9'd1, x1_q - 9'd1};
        end
        2'd2: begin
          rv       = (x1_q != '0);
          rsub     = 1'b1;
          ir_raddr = {y2_q, x1_q - 9'd1};
        end
        default: begin
          rv       = (y1_q != '0);
          rsub     = 1'b1;
          ir_raddr = {y1_q - 9'd1, x2_q};
        end
      endcase
      ir_re = rv;
    end
  end

  assign gr_re    = (state_q == ST_WIN);
  assign term     = pv_q ? {1'b0, ir_rdata} : '0;
  assign acc_next = pend_q ? (psub_q ? acc_q - term : acc_q + term) : acc_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (is_load) begin
            state_d = ST_LOAD_WR;
          end else if (fetch_ok) begin
            state_d = stale_q ? ST_DIV : ST_WIN;
          end
        end
      end
      ST_LOAD_WR: state_d = ST_IDLE;
      ST_DIV: begin
        if (dcnt_q == DCNT_W'(iat_pkg::DIV_STEPS - 1)) begin
          state_d = ST_WIN;
        end
      end
      ST_WIN: state_d = ST_RD;
      ST_RD: begin
        if (idx_q == 2'd3) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: state_d = ST_MUL;
      ST_MUL: state_d = ST_OUT;
      default: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lp_q        <= '0;
      lc_q        <= '0;
      lr_q        <= '0;
      rsum_q      <= '0;
      loaded_q    <= 1'b0;
      ep_q        <= '0;
      ec_q        <= '0;
      er_q        <= '0;
      stale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.width_wr) begin
        stale_q <= 1'b1;
      end
      // new image restarts every position
      if (take && is_load && restart) begin
        lp_q     <= '0;
        lc_q     <= '0;
        lr_q     <= '0;
        rsum_q   <= '0;
        loaded_q <= 1'b0;
        ep_q     <= '0;
        ec_q     <= '0;
        er_q     <= '0;
        stale_q  <= 1'b0;
      end
      // store one pixel
      if (state_q == ST_LOAD_WR) begin
        lp_q   <= lp_q + 19'd1;
        rsum_q <= rsum_new;
        if ({1'b0, lc_q} == wm1) begin
          lc_q <= '0;
          lr_q <= lr_q + 9'd1;
        end else begin
          lc_q <= lc_q + 9'd1;
        end
        if ((lp_q + 19'd1) >= cfg_i.n) begin
          loaded_q <= 1'b1;
        end
      end
      if ((state_q == ST_DIV) && (dcnt_q == DCNT_W'(iat_pkg::DIV_STEPS - 1))) begin
        ec_q    <= drem_d[iat_pkg::COL_W-1:0];
        er_q    <= dq_d[iat_pkg::ROW_W-1:0];
        stale_q <= 1'b0;
      end
      // result transfer and emit advance
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
        if (ep_inc == cfg_i.n) begin
          ep_q <= '0;
          ec_q <= '0;
          er_q <= '0;
        end else begin
          ep_q <= ep_inc[iat_pkg::EMIT_W-1:0];
          if ({1'b0, ec_q} == wm1) begin
            ec_q <= '0;
            er_q <= er_q + 9'd1;
          end else begin
            ec_q <= ec_q + 9'd1;
          end
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      ld_gray_q <= item_i.gray;
      dq_q      <= ep_q;
      drem_q    <= '0;
      dcnt_q    <= '0;
    end
    if (state_q == ST_DIV) begin
      dq_q   <= dq_d;
      drem_q <= drem_d;
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    if (state_q == ST_WIN) begin
      x1_q    <= x1_c;
      x2_q    <= x2_c;
      y1_q    <= y1_c;
      y2_q    <= y2_c;
      len_x_q <= {1'b0, x2_c} - {1'b0, x1_c} + 10'd1;
      len_y_q <= {1'b0, y2_c} - {1'b0, y1_c} + 10'd1;
      idx_q   <= 2'd0;
      pend_q  <= 1'b0;
      acc_q   <= '0;
    end
    if (state_q == ST_RD) begin
      acc_q  <= acc_next;
      pend_q <= 1'b1;
      pv_q   <= rv;
      psub_q <= rsub;
      idx_q  <= idx_q + 2'd1;
      cnt_q  <= iat_pkg::CNT_W'(len_x_q * len_y_q);
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_next;
    end
    // gray <= sum*keep/(count*256) is checked as gray*count*256 <= sum*keep
    if (state_q == ST_MUL) begin
      prod_a_q <= acc_q[iat_pkg::INTEG_W-1:0] * cfg_i.keep;
      prod_b_q <= iat_pkg::PROD_W'(gr_rdata * cnt_q);
    end
    if ((state_q == ST_OUT) && out_free) begin
      white_q <= ({prod_b_q[iat_pkg::PROD_W-9:0], 8'd0} <= prod_a_q) &&
                 (prod_b_q[iat_pkg::PROD_W-1:iat_pkg::PROD_W-8] == '0);
      col_q   <= ec_q;
      row_q   <= er_q;
      last_q  <= (ep_inc == cfg_i.n);
    end
  end

  iat_ram #(
    .WIDTH (iat_pkg::INTEG_W),
    .DEPTH (iat_pkg::MEM_DEPTH)
  ) u_integ_ram (
    .clk_i   (clk_i),
    .we_i    (ir_we),
    .waddr_i (wr_addr),
    .wdata_i (integ_new),
    .re_i    (ir_re),
    .raddr_i (ir_raddr),
    .rdata_o (ir_rdata)
  );

  iat_ram #(
    .WIDTH (iat_pkg::GRAY_W),
    .DEPTH (iat_pkg::MEM_DEPTH)
  ) u_gray_ram (
    .clk_i   (clk_i),
    .we_i    (ir_we),
    .waddr_i (wr_addr),
    .wdata_i (ld_gray_q),
    .re_i    (gr_re),
    .raddr_i ({er_q, ec_q}),
    .rdata_o (gr_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign white_o     = white_q;
  assign col_o       = col_q;
  assign row_o       = row_q;
  assign last_o      = last_q;

endmodule

@@ rtl/integral_image_adaptive_threshold_core.sv @@
// integral_image_adaptive_threshold_core: top level, config registers, front queue, engine
// depends on iat_pkg, iat_front, iat_engine
//
//   channel   signals                                   direction
//   in        in_valid_i/in_stall_o, command_i, gray_i   into core
//   out       out_valid_o/out_stall_i, white/col/row/last out of core
//   cfg       cfg_we_i, cfg_index_i, cfg_wdata_i         into core, write only
//
// a load is one integral ram read of the entry above, then one write
// a fetch is paced by the four corner reads on the single read port
// of the integral ram; the first fetch after a width write also runs the divider
// a fetch that finds no complete image is dropped with no result
// the two-entry input queue and the output register let each side stall on its own
// reset is asynchronous and active low; the pixel rams are not cleared

module integral_image_adaptive_threshold_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] gray_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       white_o,
  output logic [8:0] col_o,
  output logic [8:0] row_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_wdata_i
);

  logic [iat_pkg::DIM_W-1:0]  width_q, height_q;
  logic [iat_pkg::KEEP_W-1:0] keep_q;
  logic [iat_pkg::DIM_W-1:0]  w_eff, h_eff, big;
  iat_pkg::cfg_t              cfg;
  iat_pkg::item_t             item;
  logic                       item_valid, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= iat_pkg::RST_WIDTH;
      height_q <= iat_pkg::RST_HEIGHT;
      keep_q   <= iat_pkg::RST_KEEP;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iat_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        iat_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        iat_pkg::CFG_KEEP_Q8:      keep_q   <= cfg_wdata_i[iat_pkg::KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions, pixel count and window half-width
  assign w_eff = (width_q == '0) ? 10'd1 :
                 (width_q > 10'(iat_pkg::MAX_WIDTH)) ? 10'(iat_pkg::MAX_WIDTH) : width_q;
  assign h_eff = (height_q == '0) ? 10'd1 :
                 (height_q > 10'(iat_pkg::MAX_HEIGHT)) ? 10'(iat_pkg::MAX_HEIGHT) : height_q;
  assign big   = (w_eff > h_eff) ? w_eff : h_eff;

  assign cfg.w        = w_eff;
  assign cfg.h        = h_eff;
  assign cfg.n        = iat_pkg::POS_W'(w_eff * h_eff);
  assign cfg.s        = ((big >> iat_pkg::WIN_SHIFT) == '0) ? 10'd1 : (big >> iat_pkg::WIN_SHIFT);
  assign cfg.keep     = keep_q;
  assign cfg.width_wr = cfg_we_i && (cfg_index_i == iat_pkg::CFG_IMAGE_WIDTH);

  iat_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .gray_i       (gray_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .pop_i        (pop)
  );

  iat_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .white_o      (white_o),
    .col_o        (col_o),
    .row_o        (row_o),
    .last_o       (last_o)
  );

endmodule
